// ===== rtl/ctls_pkg.sv =====
package ctls_pkg;

   // Field widths
   localparam int CMD_W       = 1;
   localparam int UNIT_W      = 8;
   localparam int LAMP_W      = 8;
   localparam int PHASE_W     = 4;
   localparam int SLOT_W      = 2;
   localparam int ELAPSED_W   = 18;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   // Default timing scale, ms per unit
   localparam int STEP_MS_PER_UNIT_DEF   = 250;
   localparam int YELLOW_MS_PER_UNIT_DEF = 1000;

   // Item kinds carried in tuser
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
   localparam logic [CMD_W-1:0] CMD_BYTE = 1'b1;

   // Phase codes
   localparam logic [PHASE_W-1:0] PHASE_FIRST_RED = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_YELLOW    = 4'd4;
   localparam logic [PHASE_W-1:0] PHASE_LAST      = 4'd8;

   // Byte slot codes: which unit register the next byte loads
   localparam logic [SLOT_W-1:0] SLOT_YELLOW = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_RED    = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_GREEN  = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_UNUSED = 2'd3;

   localparam logic [UNIT_W-1:0]    UNITS_RESET = 8'd1;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [UNIT_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_now;
      logic               yellow_on;
      logic [LAMP_W-1:0]  lamp_pattern;
   } rsp_type;

   // Countdown lamp pattern per phase; upper nibble red, lower green
   function automatic logic [LAMP_W-1:0] lamp_of(input logic [PHASE_W-1:0] p);
      logic [LAMP_W-1:0] lamp;
      case (p)
         4'd0:    lamp = 8'b1111_0000;
         4'd1:    lamp = 8'b1110_0000;
         4'd2:    lamp = 8'b1100_0000;
         4'd3:    lamp = 8'b1000_0000;
         4'd4:    lamp = 8'b0000_0000;
         4'd5:    lamp = 8'b0000_1111;
         4'd6:    lamp = 8'b0000_1110;
         4'd7:    lamp = 8'b0000_1100;
         default: lamp = 8'b0000_1000;
      endcase
      return lamp;
   endfunction

endpackage

// ===== rtl/ctls_core.sv =====
module ctls_core #(
   parameter int STEP_MS_PER_UNIT   = ctls_pkg::STEP_MS_PER_UNIT_DEF,
   parameter int YELLOW_MS_PER_UNIT = ctls_pkg::YELLOW_MS_PER_UNIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_fire,
   input  ctls_pkg::req_type item,
   output ctls_pkg::rsp_type result
);
   import ctls_pkg::*;

   localparam int FAC_MAX = (STEP_MS_PER_UNIT > YELLOW_MS_PER_UNIT) ?
                            STEP_MS_PER_UNIT : YELLOW_MS_PER_UNIT;
   localparam int FAC_W   = $clog2(FAC_MAX + 1);
   localparam int DUR_W   = UNIT_W + FAC_W;
   localparam int CMP_W   = (DUR_W > ELAPSED_W) ? DUR_W : ELAPSED_W;

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [UNIT_W-1:0]    red_units_ff, red_units_in;
   logic [UNIT_W-1:0]    yellow_units_ff, yellow_units_in;
   logic [UNIT_W-1:0]    green_units_ff, green_units_in;
   logic [SLOT_W-1:0]    byte_slot_ff, byte_slot_in;

   logic [ELAPSED_W-1:0] elapsed_upd;
   logic [PHASE_W-1:0]   phase_eff;
   logic [UNIT_W-1:0]    dur_units;
   logic [FAC_W-1:0]     dur_factor;
   logic [DUR_W-1:0]     duration;
   logic                 phase_done;

   // Count ticks, saturating at full scale
   always_comb begin
      elapsed_upd = elapsed_ff;
      if (item.cmd == CMD_TICK && elapsed_ff != ELAPSED_MAX) begin
         elapsed_upd = elapsed_ff + 1'b1;
      end
   end

   // Load received bytes into the rotating unit slots
   always_comb begin
      red_units_in    = red_units_ff;
      yellow_units_in = yellow_units_ff;
      green_units_in  = green_units_ff;
      byte_slot_in    = byte_slot_ff;
      if (item.cmd == CMD_BYTE) begin
         case (byte_slot_ff)
            SLOT_YELLOW: begin
               yellow_units_in = item.rx_byte;
               byte_slot_in    = SLOT_RED;
            end
            SLOT_RED: begin
               red_units_in = item.rx_byte;
               byte_slot_in = SLOT_GREEN;
            end
            SLOT_GREEN: begin
               green_units_in = item.rx_byte;
               byte_slot_in   = SLOT_YELLOW;
            end
            default: begin
               byte_slot_in = SLOT_YELLOW;
            end
         endcase
      end
   end

   // Pick the running phase duration from the freshly updated units
   always_comb begin
      phase_eff = (phase_ff > PHASE_LAST) ? PHASE_LAST : phase_ff;
      if (phase_eff < PHASE_YELLOW) begin
         dur_units  = red_units_in;
         dur_factor = FAC_W'(STEP_MS_PER_UNIT);
      end else if (phase_eff == PHASE_YELLOW) begin
         dur_units  = yellow_units_in;
         dur_factor = FAC_W'(YELLOW_MS_PER_UNIT);
      end else begin
         dur_units  = green_units_in;
         dur_factor = FAC_W'(STEP_MS_PER_UNIT);
      end
      duration   = DUR_W'(dur_units) * DUR_W'(dur_factor);
      phase_done = CMP_W'(elapsed_upd) >= CMP_W'(duration);
   end

   // Advance the phase once the duration is reached
   always_comb begin
      elapsed_in = elapsed_upd;
      phase_in   = phase_ff;
      if (phase_done) begin
         elapsed_in = '0;
         phase_in   = (phase_eff == PHASE_LAST) ? PHASE_FIRST_RED : phase_eff + 1'b1;
      end
   end

   // Result reflects the state after this beat
   always_comb begin
      result.phase_now    = phase_in;
      result.yellow_on    = (phase_in == PHASE_YELLOW);
      result.lamp_pattern = lamp_of(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_FIRST_RED;
         elapsed_ff      <= '0;
         red_units_ff    <= UNITS_RESET;
         yellow_units_ff <= UNITS_RESET;
         green_units_ff  <= UNITS_RESET;
         byte_slot_ff    <= SLOT_YELLOW;
      end else if (item_fire) begin
         phase_ff        <= phase_in;
         elapsed_ff      <= elapsed_in;
         red_units_ff    <= red_units_in;
         yellow_units_ff <= yellow_units_in;
         green_units_ff  <= green_units_in;
         byte_slot_ff    <= byte_slot_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("phase beyond last green step");

   a_slot_used: assert property (@(posedge clock) disable iff (reset)
      byte_slot_ff != SLOT_UNUSED)
      else $error("byte slot reached unused code");

   a_phase_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      phase_ff != $past(phase_ff) |-> elapsed_ff == '0)
      else $error("phase moved without clearing elapsed time");

   a_phase_single_step: assert property (@(posedge clock) disable iff (reset)
      phase_ff == $past(phase_ff) || phase_ff == $past(phase_ff) + 4'd1 ||
      (phase_ff == PHASE_FIRST_RED && $past(phase_ff) == PHASE_LAST))
      else $error("phase skipped a step");
`endif

endmodule

// ===== rtl/ctls_out_reg.sv =====
module ctls_out_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  ctls_pkg::rsp_type                    result,
   output logic                                 free,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [ctls_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import ctls_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Room for a new result when empty or being drained this cycle
   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until the beat is taken
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(data_ff);

`ifndef NO_ASSERTIONS
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result loaded over an untaken beat");

   a_valid_drops_on_take: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !load |=> !valid_ff)
      else $error("taken beat stayed valid");

   a_phase_field_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.phase_now <= PHASE_LAST)
      else $error("result phase out of range");
`endif

endmodule

// ===== rtl/countdown_traffic_light_sequencer.sv =====
// Nine-phase countdown traffic light. Each input beat is a millisecond tick
// (tuser 0) or a duration byte (tuser 1) that loads yellow, red and green
// units in turn; every beat yields one result beat with the lamp pattern,
// the yellow lamp and the phase after that beat. Red and green steps last
// units*STEP_MS_PER_UNIT ticks, yellow lasts units*YELLOW_MS_PER_UNIT ticks,
// and a duration of zero advances the phase on every beat. One beat is taken
// per cycle while req_tready is high; a result beat passes through the input
// register, then the result register, and waits there while rsp_tready is low.
// The rate is set by the phase update in ctls_core, which selects the units,
// does one 8 x 10 bit multiply and one compare combinationally.
// While a finished result waits on rsp_tready, one more input beat is taken
// into the input register; req_tready then stays low until the result drains.
module countdown_traffic_light_sequencer #(
   parameter int STEP_MS_PER_UNIT   = ctls_pkg::STEP_MS_PER_UNIT_DEF,
   parameter int YELLOW_MS_PER_UNIT = ctls_pkg::YELLOW_MS_PER_UNIT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ctls_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic [ctls_pkg::CMD_W-1:0]           req_tuser,   // [0] cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] lamp_pattern, [8] yellow_on, [12:9] phase_now, [15:13] zero
   output logic [ctls_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import ctls_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_free;
   logic    advance;
   rsp_type result;

   // Move the held beat into the result register when there is room
   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.cmd     <= req_tuser;
         in_item_ff.rx_byte <= req_tdata[UNIT_W-1:0];
      end
   end

   ctls_core #(
      .STEP_MS_PER_UNIT   (STEP_MS_PER_UNIT),
      .YELLOW_MS_PER_UNIT (YELLOW_MS_PER_UNIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_item_ff),
      .result    (result)
   );

   ctls_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |-> !req_tready)
      else $error("input beat accepted over a held beat");

   a_held_beat_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> rsp_tvalid)
      else $error("held beat did not reach the result register");

   a_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_valid_ff)
      else $error("accepted beat lost");
`endif

endmodule

// ===== tb/ctls_light_checker.sv =====
// Watches both streams of the traffic light sequencer, predicts every result
// beat from the accepted input beats and compares it with what comes out.
module ctls_light_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ctls_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [7:0] rx_byte
   input  logic [ctls_pkg::CMD_W-1:0]         req_tuser,   // [0] cmd
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] lamp_pattern, [8] yellow_on, [12:9] phase_now, [15:13] zero
   input  logic [ctls_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   import ctls_pkg::*;

   localparam int STEP_MS   = STEP_MS_PER_UNIT_DEF;
   localparam int YELLOW_MS = YELLOW_MS_PER_UNIT_DEF;
   localparam int NUM_PHASES = 9;

   // Shadow copy of the light's state
   logic [PHASE_W-1:0]   light_phase;
   logic [ELAPSED_W-1:0] elapsed_ms;
   logic [UNIT_W-1:0]    red_units;
   logic [UNIT_W-1:0]    yellow_units;
   logic [UNIT_W-1:0]    green_units;
   logic [SLOT_W-1:0]    next_slot;

   rsp_type expected_lights[$];

   // Apply one beat to the shadow state and return the light shown after it
   function automatic rsp_type advance_light(input logic [CMD_W-1:0] cmd,
                                             input logic [UNIT_W-1:0] units);
      int unsigned        hold_ms;
      logic [PHASE_W-1:0] shown;
      rsp_type            view;
      if (cmd == CMD_TICK) begin
         if (elapsed_ms != ELAPSED_MAX)
            elapsed_ms = elapsed_ms + 1'b1;
      end else begin
         case (next_slot)
            SLOT_YELLOW: begin
               yellow_units = units;
               next_slot    = SLOT_RED;
            end
            SLOT_RED: begin
               red_units = units;
               next_slot = SLOT_GREEN;
            end
            SLOT_GREEN: begin
               green_units = units;
               next_slot   = SLOT_YELLOW;
            end
            default: next_slot = SLOT_YELLOW;
         endcase
      end

      // Duration of the running phase, always from the current units
      if (light_phase < PHASE_YELLOW)
         hold_ms = red_units * STEP_MS;
      else if (light_phase == PHASE_YELLOW)
         hold_ms = yellow_units * YELLOW_MS;
      else
         hold_ms = green_units * STEP_MS;

      if (elapsed_ms >= hold_ms) begin
         elapsed_ms  = '0;
         light_phase = (light_phase + 1 < NUM_PHASES) ? light_phase + 1'b1 : PHASE_FIRST_RED;
      end

      shown = (light_phase < NUM_PHASES) ? light_phase : PHASE_LAST;
      case (shown)
         4'd0:    view.lamp_pattern = 8'hF0;
         4'd1:    view.lamp_pattern = 8'hE0;
         4'd2:    view.lamp_pattern = 8'hC0;
         4'd3:    view.lamp_pattern = 8'h80;
         4'd4:    view.lamp_pattern = 8'h00;
         4'd5:    view.lamp_pattern = 8'h0F;
         4'd6:    view.lamp_pattern = 8'h0E;
         4'd7:    view.lamp_pattern = 8'h0C;
         default: view.lamp_pattern = 8'h08;
      endcase
      view.yellow_on = (shown == PHASE_YELLOW);
      view.phase_now = shown;
      return view;
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         light_phase  = PHASE_FIRST_RED;
         elapsed_ms   = '0;
         red_units    = UNITS_RESET;
         yellow_units = UNITS_RESET;
         green_units  = UNITS_RESET;
         next_slot    = SLOT_YELLOW;
         expected_lights.delete();
         mismatches   = 0;
         outstanding  <= 0;
      end else begin
         // Check a result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(rsp_type)-1:0];
            if (expected_lights.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result beat: lamp=%02h yellow=%0d phase=%0d",
                           seen.lamp_pattern, seen.yellow_on, seen.phase_now);
               mismatches = mismatches + 1;
            end else begin
               want = expected_lights.pop_front();
               if (seen.lamp_pattern !== want.lamp_pattern ||
                   seen.yellow_on !== want.yellow_on ||
                   seen.phase_now !== want.phase_now) begin
                  if (mismatches < 10)
                     $display({"result mismatch at %0t: expected lamp=%02h yellow=%0d ",
                               "phase=%0d, got lamp=%02h yellow=%0d phase=%0d"},
                              $realtime, want.lamp_pattern, want.yellow_on,
                              want.phase_now, seen.lamp_pattern, seen.yellow_on,
                              seen.phase_now);
                  mismatches = mismatches + 1;
               end
            end
         end

         // Predict the result of an accepted input beat
         if (req_tvalid && req_tready)
            expected_lights.push_back(advance_light(req_tuser, req_tdata[UNIT_W-1:0]));

         outstanding <= expected_lights.size();
      end
   end

endmodule

// ===== tb/tb_countdown_traffic_light_sequencer.sv =====
module tb_countdown_traffic_light_sequencer;

   import ctls_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] rx_byte
   logic [CMD_W-1:0]       req_tuser;   // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [7:0] lamp_pattern, [8] yellow_on, [12:9] phase_now, [15:13] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int outstanding;
   int beats_sent;
   bit sender_eager;
   bit sink_eager;

   countdown_traffic_light_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ctls_light_checker light_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one beat after a random gap (none when sender_eager) and hold it until taken
   task automatic send_beat(input logic [CMD_W-1:0] kind, input logic [UNIT_W-1:0] value);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // Millisecond ticks carry junk in the data byte
   task automatic send_ticks(input int count);
      repeat (count) send_beat(CMD_TICK, UNIT_W'($urandom_range(0, 255)));
   endtask

   // Full yellow, red, green byte triple
   task automatic send_units(input logic [UNIT_W-1:0] yellow, input logic [UNIT_W-1:0] red,
                             input logic [UNIT_W-1:0] green);
      send_beat(CMD_BYTE, yellow);
      send_beat(CMD_BYTE, red);
      send_beat(CMD_BYTE, green);
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Mostly short durations so phases turn over often, now and then a long one
   function automatic logic [UNIT_W-1:0] pick_units();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 8'd0;
      else if (roll < 75)
         return 8'd1;
      else if (roll < 92)
         return UNIT_W'($urandom_range(2, 3));
      return UNIT_W'($urandom_range(0, 255));
   endfunction

   // Result side: random stalls with stretches of steady ready
   initial begin
      int stall;
      int left;
      left       = 0;
      rsp_tready = 1'b0;
      forever begin
         if (left == 0) begin
            sink_eager = ($urandom_range(0, 3) == 0);
            left       = $urandom_range(10, 60);
         end
         left--;
         stall = sink_eager ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int  roll;
      bit  paused;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_TICK;
      beats_sent   = 0;
      paused       = 1'b0;
      sender_eager = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset durations, then zero durations walking every phase and wrapping
      send_ticks(3);
      send_units(8'd0, 8'd0, 8'd0);
      sender_eager = 1'b1;
      send_ticks(10);
      sender_eager = 1'b0;
      // Largest durations, then a new triple with a red of zero while yellow runs
      send_units(8'd255, 8'd255, 8'd255);
      send_ticks(3);
      send_units(8'hAA, 8'h00, 8'h55);

      drain_results();

      // Random byte triples, tick runs and stray bytes
      while (beats_sent < 1150) begin
         sender_eager = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 55)
            send_ticks($urandom_range(1, 40));
         else if (roll < 60)
            send_ticks($urandom_range(200, 300));
         else if (roll < 90)
            send_units(pick_units(), pick_units(), pick_units());
         else
            send_beat(CMD_BYTE, UNIT_W'($urandom_range(0, 255)));
         if (!paused && beats_sent >= 600) begin
            paused = 1'b1;
            drain_results();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ctls_pkg.sv
rtl/ctls_core.sv
rtl/ctls_out_reg.sv
rtl/countdown_traffic_light_sequencer.sv
tb/ctls_light_checker.sv
tb/tb_countdown_traffic_light_sequencer.sv
